// ----- sv/hpw_pkg.sv -----
// Package for the haversine proximity warning block: widths, fixed-point
// constants, configuration register indexes and the CORDIC table functions.
// It depends on nothing else.
package hpw_pkg;

    localparam int ID_W    = 8;
    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int DIST_W  = 31;
    localparam int ANG_W   = 44;
    localparam int SC_W    = 33;
    localparam int SQ_W    = 62;
    localparam int SQRT_STEPS = 31;
    localparam int RAD_W   = 30;
    localparam int CFG_W   = 32;

    typedef logic signed [ANG_W-1:0] ang_t;

    typedef enum logic [1:0] {
        CFG_OWN_LAT   = 2'd0,
        CFG_OWN_LON   = 2'd1,
        CFG_WARN_DIST = 2'd2
    } cfg_index_t;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG7_K = (PI_Q60 + 64'd450000000) / 64'd900000000;
    localparam ang_t PI_Q40      = ANG_W'((PI_Q60 + (64'd1 << 19)) >> 20);
    localparam ang_t HALF_PI_Q40 = ANG_W'((PI_Q60 + (64'd1 << 20)) >> 21);
    localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
    localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
    localparam logic [RAD_W-1:0]  EARTH_R_CM = 30'd637100000;
    localparam logic [DIST_W-1:0] RANGE_MAX  = 31'd2001508680;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = '0;
        for (int j = 0; j < 32; j++) begin
            b = 64'd1 << (62 - 2 * j);
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Restoring long division, used only while the tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic ang_t atan_q40(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        if (i == 0) begin
            sum = PI_Q60;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = udiv64(64'd1 << e, 64'(2 * k + 1));
                    if ((k & 1) == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
        end
        return ANG_W'((sum + (64'd1 << 21)) >> 22);
    endfunction

    function automatic ang_t inv_gain_q40(input int stages);
        logic [63:0] g;
        logic [63:0] g31;
        logic [63:0] q;
        logic [63:0] r;
        g = 64'd1 << 62;
        for (int i = 0; i < 64; i++) begin
            if (i < stages && 2 * i < 64)
                g = g + (g >> (2 * i));
        end
        g31 = isqrt64(g);
        q   = udiv64(64'd1 << 63, g31);
        r   = (64'd1 << 63) - q * g31;
        return ANG_W'((q << 8) + udiv64(r << 8, g31));
    endfunction

endpackage

// ----- sv/hpw_cordic.sv -----
// Pipelined CORDIC with one register stage per iteration, in rotation or
// vectoring mode. Depends on hpw_pkg for the angle type and table.
module hpw_cordic #(
    parameter int STAGES    = 24,
    parameter bit VECTORING = 1'b0
) (
    input  logic          clk,
    input  logic          ce,
    input  hpw_pkg::ang_t x_in,
    input  hpw_pkg::ang_t y_in,
    input  hpw_pkg::ang_t z_in,
    output hpw_pkg::ang_t x_out,
    output hpw_pkg::ang_t y_out,
    output hpw_pkg::ang_t z_out
);

    hpw_pkg::ang_t x_reg [STAGES];
    hpw_pkg::ang_t y_reg [STAGES];
    hpw_pkg::ang_t z_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam hpw_pkg::ang_t ATAN = hpw_pkg::atan_q40(i);
        hpw_pkg::ang_t xp;
        hpw_pkg::ang_t yp;
        hpw_pkg::ang_t zp;
        hpw_pkg::ang_t xs;
        hpw_pkg::ang_t ys;
        logic          ccw;

        if (i == 0) begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
        end else begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
        end

        assign xs  = xp >>> i;
        assign ys  = yp >>> i;
        assign ccw = VECTORING ? (yp < 0) : (zp >= 0);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (ccw)
                begin
                    x_reg[i] <= xp - ys;
                    y_reg[i] <= yp + xs;
                    z_reg[i] <= zp - ATAN;
                end
                else
                begin
                    x_reg[i] <= xp + ys;
                    y_reg[i] <= yp - xs;
                    z_reg[i] <= zp + ATAN;
                end
            end
        end
    end

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];
    assign z_out = z_reg[STAGES-1];

endmodule

// ----- sv/haversine_proximity_warning.sv -----
// Throughput: one beat per cycle unless the output is stalled; the two CORDIC chains
// and the square root pipeline are fully staged; their iteration counts set the depth.
// Reset clears all valid bits and loads the default own position and warning distance.
// Depends on hpw_pkg and hpw_cordic.
module haversine_proximity_warning #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sender_id [7:0], peer_latitude [38:8], peer_longitude [70:39], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_id [7:0], range_cm [38:8], collision_warning [39]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int N = CORDIC_STAGES;
    localparam int P = 41 + 2 * N;
    localparam hpw_pkg::ang_t INV_GAIN = hpw_pkg::inv_gain_q40(N);
    localparam logic signed [33:0] K_S = $signed({2'b00, hpw_pkg::DEG7_K[31:0]});

    logic signed [hpw_pkg::LAT_W-1:0]  own_lat_reg;
    logic signed [hpw_pkg::LON_W-1:0]  own_lon_reg;
    logic        [hpw_pkg::DIST_W-1:0] warn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_lat_reg <= 31'sd129718000;
            own_lon_reg <= 32'sd775948000;
            warn_reg    <= 31'd3000;
        end
        else if (cfg_we)
        begin
            case (hpw_pkg::cfg_index_t'(cfg_index))
                hpw_pkg::CFG_OWN_LAT:   own_lat_reg <= $signed(cfg_wdata[30:0]);
                hpw_pkg::CFG_OWN_LON:   own_lon_reg <= $signed(cfg_wdata);
                hpw_pkg::CFG_WARN_DIST: warn_reg    <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_load;
    logic [P-1:0] vld_reg;
    logic [hpw_pkg::ID_W-1:0] id_reg [P];

    assign ce            = !(vld_reg[P-1] && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = ce;
    assign out_load      = vld_reg[P-1] && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[P-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            id_reg[0] <= s_axis_tdata[7:0];
            for (int i = 1; i < P; i++)
                id_reg[i] <= id_reg[i-1];
        end
    end

    // Differences and latitudes.
    logic signed [hpw_pkg::LAT_W-1:0] lat2;
    logic signed [hpw_pkg::LON_W-1:0] lon2;
    logic signed [33:0] dlat_raw;
    logic signed [33:0] dlon_raw;
    logic signed [33:0] dlat_w;
    logic signed [33:0] dlon_w;
    logic signed [31:0] dlat_reg;
    logic signed [31:0] dlon_reg;
    logic signed [hpw_pkg::LAT_W-1:0] lat1_reg;
    logic signed [hpw_pkg::LAT_W-1:0] lat2_reg;

    assign lat2     = $signed(s_axis_tdata[38:8]);
    assign lon2     = $signed(s_axis_tdata[70:39]);
    assign dlat_raw = 34'(lat2) - 34'(own_lat_reg);
    assign dlon_raw = 34'(lon2) - 34'(own_lon_reg);

    always_comb
    begin
        dlat_w = dlat_raw;
        if (dlat_raw > hpw_pkg::HALF_TURN)
            dlat_w = dlat_raw - hpw_pkg::FULL_TURN;
        else if (dlat_raw < -hpw_pkg::HALF_TURN)
            dlat_w = dlat_raw + hpw_pkg::FULL_TURN;
        dlon_w = dlon_raw;
        if (dlon_raw > hpw_pkg::HALF_TURN)
            dlon_w = dlon_raw - hpw_pkg::FULL_TURN;
        else if (dlon_raw < -hpw_pkg::HALF_TURN)
            dlon_w = dlon_raw + hpw_pkg::FULL_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dlat_reg <= dlat_w[31:0];
            dlon_reg <= dlon_w[31:0];
            lat1_reg <= own_lat_reg;
            lat2_reg <= lat2;
        end
    end

    // Conversion to radians.
    logic signed [65:0] prod_reg [4];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_reg[0] <= 66'(34'(dlat_reg) * K_S);
            prod_reg[1] <= 66'(34'(dlon_reg) * K_S);
            prod_reg[2] <= 66'(34'(lat1_reg) * K_S);
            prod_reg[3] <= 66'(34'(lat2_reg) * K_S);
        end
    end

    hpw_pkg::ang_t ang_in [4];
    hpw_pkg::ang_t fold_z [4];
    logic [3:0]    fold_n;
    hpw_pkg::ang_t z_reg [4];
    logic [3:0]    fold_neg_reg;

    always_comb
    begin
        ang_in[0] = hpw_pkg::ANG_W'((prod_reg[0] + 66'sd2097152) >>> 22);
        ang_in[1] = hpw_pkg::ANG_W'((prod_reg[1] + 66'sd2097152) >>> 22);
        ang_in[2] = hpw_pkg::ANG_W'((prod_reg[2] + 66'sd1048576) >>> 21);
        ang_in[3] = hpw_pkg::ANG_W'((prod_reg[3] + 66'sd1048576) >>> 21);
        for (int u = 0; u < 4; u++)
        begin
            fold_z[u] = ang_in[u];
            fold_n[u] = 1'b0;
            if (ang_in[u] > hpw_pkg::HALF_PI_Q40)
            begin
                fold_z[u] = ang_in[u] - hpw_pkg::PI_Q40;
                fold_n[u] = 1'b1;
            end
            else if (ang_in[u] < -hpw_pkg::HALF_PI_Q40)
            begin
                fold_z[u] = ang_in[u] + hpw_pkg::PI_Q40;
                fold_n[u] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int u = 0; u < 4; u++)
                z_reg[u] <= fold_z[u];
            fold_neg_reg <= fold_n;
        end
    end

    logic [3:0]    neg_reg [N];
    hpw_pkg::ang_t rx [4];
    hpw_pkg::ang_t ry [4];
    hpw_pkg::ang_t rz [4];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg_reg[0] <= fold_neg_reg;
            for (int i = 1; i < N; i++)
                neg_reg[i] <= neg_reg[i-1];
        end
    end

    for (genvar u = 0; u < 4; u++) begin : g_rot
        hpw_cordic #(
            .STAGES    (N),
            .VECTORING (1'b0)
        ) u_rot (
            .clk   (clk),
            .ce    (ce),
            .x_in  (INV_GAIN),
            .y_in  ('0),
            .z_in  (z_reg[u]),
            .x_out (rx[u]),
            .y_out (ry[u]),
            .z_out (rz[u])
        );
    end

    // Sine of the half differences, cosine of the latitudes, in Q30.
    logic signed [hpw_pkg::SC_W-1:0] sc_reg [4];
    hpw_pkg::ang_t sc_src [4];
    hpw_pkg::ang_t sc_rnd [4];

    always_comb
    begin
        sc_src[0] = ry[0];
        sc_src[1] = ry[1];
        sc_src[2] = rx[2];
        sc_src[3] = rx[3];
        for (int u = 0; u < 4; u++)
        begin
            sc_rnd[u] = (sc_src[u] + 44'sd512) >>> 10;
            if (neg_reg[N-1][u])
                sc_rnd[u] = -sc_rnd[u];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int u = 0; u < 4; u++)
                sc_reg[u] <= hpw_pkg::SC_W'(sc_rnd[u]);
        end
    end

    logic signed [65:0] sq1_reg;
    logic signed [65:0] cc_reg;
    logic signed [65:0] sq2_reg;
    logic signed [65:0] sq1_r;
    logic signed [65:0] cc_r;
    logic signed [65:0] sq2_r;
    logic signed [31:0] t1_reg;
    logic signed [31:0] t2_reg;
    logic signed [31:0] t3_reg;
    logic signed [31:0] t1d_reg;
    logic signed [63:0] p23_reg;
    logic signed [63:0] p23_r;
    logic signed [35:0] a_sum;
    logic [30:0]        rad_reg [2];

    assign sq1_r = (sq1_reg + 66'sd536870912) >>> 30;
    assign cc_r  = (cc_reg  + 66'sd536870912) >>> 30;
    assign sq2_r = (sq2_reg + 66'sd536870912) >>> 30;
    assign p23_r = (p23_reg + 64'sd536870912) >>> 30;
    assign a_sum = 36'(t1d_reg) + 36'(p23_r);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq1_reg <= 66'(sc_reg[0] * sc_reg[0]);
            sq2_reg <= 66'(sc_reg[1] * sc_reg[1]);
            cc_reg  <= 66'(sc_reg[2] * sc_reg[3]);
            t1_reg  <= sq1_r[31:0];
            t2_reg  <= cc_r[31:0];
            t3_reg  <= sq2_r[31:0];
            p23_reg <= t2_reg * t3_reg;
            t1d_reg <= t1_reg;
            if (a_sum < 0)
            begin
                rad_reg[0] <= '0;
                rad_reg[1] <= 31'h4000_0000;
            end
            else if (a_sum > 36'sh0_4000_0000)
            begin
                rad_reg[0] <= 31'h4000_0000;
                rad_reg[1] <= '0;
            end
            else
            begin
                rad_reg[0] <= a_sum[30:0];
                rad_reg[1] <= 31'h4000_0000 - a_sum[30:0];
            end
        end
    end

    // Digit-by-digit square roots, one result bit per stage.
    logic [hpw_pkg::SQ_W-1:0] sq_v_reg [2][hpw_pkg::SQRT_STEPS];
    logic [hpw_pkg::SQ_W-1:0] sq_r_reg [2][hpw_pkg::SQRT_STEPS];

    for (genvar u = 0; u < 2; u++) begin : g_sqrt
        for (genvar j = 0; j < hpw_pkg::SQRT_STEPS; j++) begin : g_step
            localparam logic [hpw_pkg::SQ_W-1:0] BIT =
                hpw_pkg::SQ_W'(1) << (2 * (hpw_pkg::SQRT_STEPS - 1 - j));
            logic [hpw_pkg::SQ_W-1:0] vp;
            logic [hpw_pkg::SQ_W-1:0] rp;
            logic [hpw_pkg::SQ_W-1:0] trial;

            if (j == 0) begin : g_first
                assign vp = hpw_pkg::SQ_W'(rad_reg[u]) << 30;
                assign rp = '0;
            end else begin : g_next
                assign vp = sq_v_reg[u][j-1];
                assign rp = sq_r_reg[u][j-1];
            end

            assign trial = rp + BIT;

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (vp >= trial)
                    begin
                        sq_v_reg[u][j] <= vp - trial;
                        sq_r_reg[u][j] <= (rp >> 1) + BIT;
                    end
                    else
                    begin
                        sq_v_reg[u][j] <= vp;
                        sq_r_reg[u][j] <= rp >> 1;
                    end
                end
            end
        end
    end

    hpw_pkg::ang_t vx_in;
    hpw_pkg::ang_t vy_in;
    hpw_pkg::ang_t vx;
    hpw_pkg::ang_t vy;
    hpw_pkg::ang_t vz;

    assign vx_in = hpw_pkg::ang_t'(hpw_pkg::ANG_W'(sq_r_reg[1][hpw_pkg::SQRT_STEPS-1][30:0]) << 10);
    assign vy_in = hpw_pkg::ang_t'(hpw_pkg::ANG_W'(sq_r_reg[0][hpw_pkg::SQRT_STEPS-1][30:0]) << 10);

    hpw_cordic #(
        .STAGES    (N),
        .VECTORING (1'b1)
    ) u_vec (
        .clk   (clk),
        .ce    (ce),
        .x_in  (vx_in),
        .y_in  (vy_in),
        .z_in  ('0),
        .x_out (vx),
        .y_out (vy),
        .z_out (vz)
    );

    // Central angle to centimetres.
    logic [42:0] ang;
    logic [52:0] rhi_reg;
    logic [49:0] rlo_reg;
    logic [53:0] rsum;
    logic [33:0] rrnd;
    logic [hpw_pkg::DIST_W-1:0] range_reg;

    assign ang  = (vz > 0) ? {vz[41:0], 1'b0} : '0;
    assign rsum = 54'(rhi_reg) + 54'(rlo_reg >> 20);
    assign rrnd = 34'((rsum + 54'd524288) >> 20);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rhi_reg <= 53'(hpw_pkg::EARTH_R_CM) * 53'(ang[42:20]);
            rlo_reg <= 50'(hpw_pkg::EARTH_R_CM) * 50'(ang[19:0]);
            if (rrnd > 34'(hpw_pkg::RANGE_MAX))
                range_reg <= hpw_pkg::RANGE_MAX;
            else
                range_reg <= rrnd[30:0];
        end
    end

    // Output register.
    logic [hpw_pkg::ID_W-1:0]   out_id_reg;
    logic [hpw_pkg::DIST_W-1:0] out_range_reg;
    logic                       out_warn_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_id_reg    <= id_reg[P-1];
            out_range_reg <= range_reg;
            out_warn_reg  <= (range_reg < warn_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_warn_reg, out_range_reg, out_id_reg};

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled although the output register is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_range_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_range_reg <= hpw_pkg::RANGE_MAX))
        else $error("range above saturation limit");

    a_warn_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_warn_reg == (out_range_reg < warn_reg)))
        else $error("warning flag disagrees with range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
